FILE: rtl/sus_pkg.sv
// ----------------------------------------------------------------------------
// Sorted unique set package
// Shared sizes, operation and status codes, and the controller command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package sus_pkg;

    localparam int CAPACITY  = 16;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int VAL_W     = 32;
    localparam int OUT_CNT_W = 5;

    typedef logic signed [VAL_W-1:0] t_value;
    typedef logic [CNT_W-1:0]        t_count;

    typedef enum logic [1:0] {
        MODE_INSERT  = 2'd0,
        MODE_DELETE  = 2'd1,
        MODE_DEL_MIN = 2'd2,
        MODE_DEL_MAX = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/sus_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted unique set controller
// Sequences capture, execution and result loading for one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module sus_ctrl import sus_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_stall,
    output logic o_valid,
    input  wire  i_stall,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   w_out_free;

    assign w_out_free = !r_valid || !i_stall;

    always_comb begin
        o_cmd.load_in  = (r_state == S_IDLE) && i_valid;
        o_cmd.exec     = (r_state == S_EXEC);
        o_cmd.load_out = (r_state == S_LOAD) && w_out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The result register stays full until the downstream side takes it.
    assign n_valid = o_cmd.load_out ? 1'b1 : (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

    a_exec_follows_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $past(o_cmd.load_in)
    ) else $error("execution without an accepted transaction");

    a_valid_from_load: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> $past(r_state == S_LOAD)
    ) else $error("result valid raised outside the load state");

    a_load_waits: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && r_valid && i_stall) |=> (r_state == S_LOAD)
    ) else $error("pending result overwritten while stalled");

endmodule

`default_nettype wire

FILE: rtl/sus_dpath.sv
// ----------------------------------------------------------------------------
// Sorted unique set datapath
// Shift-register sorted array with per-slot compare and shift control.
// ----------------------------------------------------------------------------
`default_nettype none

module sus_dpath import sus_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  t_cmd                 i_cmd,
    input  wire  [1:0]           i_mode,
    input  wire  signed [31:0]   i_value,
    output logic [1:0]           o_status,
    output logic signed [31:0]   o_removed_value,
    output logic signed [31:0]   o_smallest,
    output logic signed [31:0]   o_largest,
    output logic [4:0]           o_entry_count,
    output logic                 o_is_empty
);

    t_mode   r_mode;
    t_value  r_value;
    t_value  r_slot [CAPACITY];
    t_value  n_slot [CAPACITY];
    t_count  r_count, n_count;
    t_status r_res_status, n_res_status;
    t_value  r_res_removed, n_res_removed;

    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_eq;
    logic [CAPACITY-1:0] w_prev_lt;
    t_value              w_up   [CAPACITY];
    t_value              w_down [CAPACITY];
    t_count              w_last_cnt;
    logic [IDX_W-1:0]    w_last_idx;
    t_value              w_last;
    logic                w_found;
    logic                w_full;
    logic                w_empty;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode  <= t_mode'(i_mode);
            r_value <= i_value;
        end
    end

    // Each slot compares against the operand on its own; the array is
    // ascending, so the less-than flags form a prefix.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_lt[i] = (t_count'(i) < r_count) && (r_slot[i] < r_value);
            w_eq[i] = (t_count'(i) < r_count) && (r_slot[i] == r_value);
        end
        w_up[CAPACITY-1] = r_slot[CAPACITY-1];
        for (int i = 0; i < CAPACITY - 1; i++) begin
            w_up[i] = r_slot[i+1];
        end
        w_down[0] = r_value;
        for (int i = 1; i < CAPACITY; i++) begin
            w_down[i] = r_slot[i-1];
        end
    end

    assign w_prev_lt  = {w_lt[CAPACITY-2:0], 1'b1};
    assign w_found    = |w_eq;
    assign w_full     = (r_count == t_count'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_last_cnt = r_count - t_count'(1);
    assign w_last_idx = w_last_cnt[IDX_W-1:0];
    assign w_last     = r_slot[w_last_idx];

    always_comb begin
        n_slot        = r_slot;
        n_count       = r_count;
        n_res_status  = r_res_status;
        n_res_removed = r_res_removed;
        if (i_cmd.exec) begin
            n_res_status  = ST_DONE;
            n_res_removed = '0;
            if (r_mode == MODE_INSERT) begin
                if (w_found) begin
                    n_res_status = ST_MISS;
                end else if (w_full) begin
                    n_res_status = ST_FULL;
                end else begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (w_lt[i]) begin
                            n_slot[i] = r_slot[i];
                        end else if (w_prev_lt[i]) begin
                            n_slot[i] = r_value;
                        end else begin
                            n_slot[i] = w_down[i];
                        end
                    end
                    n_count = r_count + t_count'(1);
                end
            end else if (w_empty) begin
                n_res_status = ST_EMPTY;
            end else begin
                case (r_mode)
                    MODE_DELETE: begin
                        if (!w_found) begin
                            n_res_status = ST_MISS;
                        end else begin
                            // Slots at and above the match close the gap.
                            for (int i = 0; i < CAPACITY; i++) begin
                                n_slot[i] = w_lt[i] ? r_slot[i] : w_up[i];
                            end
                            n_res_removed = r_value;
                            n_count       = w_last_cnt;
                        end
                    end
                    MODE_DEL_MIN: begin
                        n_slot        = w_up;
                        n_res_removed = r_slot[0];
                        n_count       = w_last_cnt;
                    end
                    MODE_DEL_MAX: begin
                        n_res_removed = w_last;
                        n_count       = w_last_cnt;
                    end
                    default: begin
                        n_res_status = ST_DONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot        <= n_slot;
        r_res_status  <= n_res_status;
        r_res_removed <= n_res_removed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status        <= r_res_status;
            o_removed_value <= r_res_removed;
            o_smallest      <= w_empty ? t_value'(0) : r_slot[0];
            o_largest       <= w_empty ? t_value'(0) : w_last;
            o_entry_count   <= OUT_CNT_W'(r_count);
            o_is_empty      <= w_empty;
        end
    end

    a_count_bound: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(CAPACITY)
    ) else $error("entry count above capacity");

    for (genvar g = 0; g < CAPACITY - 1; g++) begin : g_order_chk
        a_ascending: assert property (
            @(posedge i_clk) disable iff (!i_rst_n)
            (t_count'(g + 1) < r_count) |-> (r_slot[g] < r_slot[g+1])
        ) else $error("held values not strictly ascending");
    end

endmodule

`default_nettype wire

FILE: rtl/sorted_unique_set.sv
// ----------------------------------------------------------------------------
// Sorted unique set
// Bounded ascending set of distinct signed values with insert, delete,
// remove-smallest and remove-largest operations.
// ----------------------------------------------------------------------------
// Order: capture, array update, result load; o_valid rises with the result
// load, and a new transaction is taken only after it. The result load waits
// while the result register is stalled downstream.
// Reset: synchronous; the set is empty afterwards, array contents are not
// cleared since only slots below the entry count are ever read.
`default_nettype none

module sorted_unique_set import sus_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire  [1:0]         i_mode,
    input  wire  signed [31:0] i_value,
    output logic               o_valid,
    input  wire                i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_removed_value,
    output logic signed [31:0] o_smallest,
    output logic signed [31:0] o_largest,
    output logic [4:0]         o_entry_count,
    output logic               o_is_empty
);

    t_cmd w_cmd;

    sus_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd)
    );

    sus_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_mode          (i_mode),
        .i_value         (i_value),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_smallest      (o_smallest),
        .o_largest       (o_largest),
        .o_entry_count   (o_entry_count),
        .o_is_empty      (o_is_empty)
    );

endmodule

`default_nettype wire
